// ===== src/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

   localparam int MAX_TIMERS_DEF = 64;
   localparam int TIME_BITS_DEF  = 32;
   localparam int RES_CAP        = 64;
   localparam int ID_W           = 6;
   localparam int TIME_IN_W      = 32;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_ADJ  = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE      = 2'd0,
      KIND_ARMED     = 2'd1,
      KIND_NOT_ARMED = 2'd2,
      KIND_EXPIRED   = 2'd3
   } kind_type;

   typedef struct packed {
      logic armed;
      logic expiry;
      logic next;
      logic prev;
   } stq_wr_en_type;

   typedef struct packed {
      logic            valid;
      kind_type        kind;
      logic [ID_W-1:0] id;
      logic            last;
   } stq_push_type;

endpackage

`default_nettype wire

// ===== src/stq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stq_req_if import stq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [ID_W-1:0]      conn_id;
   logic [TIME_IN_W-1:0] expire_time;
   logic [TIME_IN_W-1:0] now_time;

   modport source (output valid, op, conn_id, expire_time, now_time, input ready);
   modport sink   (input valid, op, conn_id, expire_time, now_time, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
   logic            valid;
   logic            ready;
   kind_type        kind;
   logic [ID_W-1:0] expired_id;
   logic            last;

   modport source (output valid, kind, expired_id, last, input ready);
   modport sink   (input valid, kind, expired_id, last, output ready);
endinterface

`default_nettype wire

// ===== src/stq_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_table import stq_pkg::*; #(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   localparam int AW = $clog2(MAX_TIMERS),
   localparam int LW = $clog2(MAX_TIMERS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic                      rd_armed,
   output logic [TIME_BITS-1:0]      rd_expiry,
   output logic [LW-1:0]             rd_next,
   output logic [LW-1:0]             rd_prev,
   input  wire stq_wr_en_type        wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic                 wr_armed,
   input  wire logic [TIME_BITS-1:0] wr_expiry,
   input  wire logic [LW-1:0]        wr_next,
   input  wire logic [LW-1:0]        wr_prev
);

   logic                 armed_mem  [MAX_TIMERS];
   logic [TIME_BITS-1:0] expiry_mem [MAX_TIMERS];
   logic [LW-1:0]        next_mem   [MAX_TIMERS];
   logic [LW-1:0]        prev_mem   [MAX_TIMERS];

   always_ff @(posedge clock) begin
      if (wr_en.armed) armed_mem[wr_addr] <= wr_armed;
      if (wr_en.expiry) expiry_mem[wr_addr] <= wr_expiry;
      if (wr_en.next) next_mem[wr_addr] <= wr_next;
      if (wr_en.prev) prev_mem[wr_addr] <= wr_prev;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_armed  <= armed_mem[rd_addr];
         rd_expiry <= expiry_mem[rd_addr];
         rd_next   <= next_mem[rd_addr];
         rd_prev   <= prev_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/stq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl import stq_pkg::*; #(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   localparam int AW = $clog2(MAX_TIMERS),
   localparam int LW = $clog2(MAX_TIMERS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire op_type               req_op,
   input  wire logic [ID_W-1:0]      req_conn_id,
   input  wire logic [TIME_IN_W-1:0] req_expire_time,
   input  wire logic [TIME_IN_W-1:0] req_now_time,
   input  wire logic                 can_push,
   output stq_push_type              push,
   output logic                      rd_en,
   output logic [AW-1:0]             rd_addr,
   input  wire logic                 rd_armed,
   input  wire logic [TIME_BITS-1:0] rd_expiry,
   input  wire logic [LW-1:0]        rd_next,
   input  wire logic [LW-1:0]        rd_prev,
   output stq_wr_en_type             wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic                      wr_armed,
   output logic [TIME_BITS-1:0]      wr_expiry,
   output logic [LW-1:0]             wr_next,
   output logic [LW-1:0]             wr_prev
);

   localparam logic [LW-1:0] NIL = LW'(MAX_TIMERS);
   localparam int CNT_W = $clog2(RES_CAP + 1);

   typedef enum logic [14:0] {
      ST_CLEAR    = 15'h0001,
      ST_IDLE     = 15'h0002,
      ST_CHECK    = 15'h0004,
      ST_UNL_P    = 15'h0008,
      ST_UNL_N    = 15'h0010,
      ST_UNL_E    = 15'h0020,
      ST_WALK     = 15'h0040,
      ST_WALK_CHK = 15'h0080,
      ST_INS_E    = 15'h0100,
      ST_INS_P    = 15'h0200,
      ST_INS_C    = 15'h0400,
      ST_TICK_CHK = 15'h0800,
      ST_TICK_N   = 15'h1000,
      ST_TICK_H   = 15'h2000,
      ST_RESP     = 15'h4000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [LW-1:0]        first_ff, first_in;
   logic [LW-1:0]        last_ff, last_in;
   logic [LW-1:0]        p_ff, p_in;
   logic [LW-1:0]        c_ff, c_in;
   op_type               op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   kind_type             kind_ff, kind_in;
   logic                 pend_v_ff, pend_v_in;
   logic [LW-1:0]        pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [AW-1:0] e_addr;
   logic [LW-1:0] e_link;

   assign e_addr    = AW'(id_ff);
   assign e_link    = LW'(id_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         first_ff  <= NIL;
         last_ff   <= NIL;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      c_ff       <= c_in;
      op_ff      <= op_in;
      id_ff      <= id_in;
      time_ff    <= time_in;
      now_ff     <= now_in;
      kind_ff    <= kind_in;
      pend_id_ff <= pend_id_in;
      cnt_ff     <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      p_in       = p_ff;
      c_in       = c_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      time_in    = time_ff;
      now_in     = now_ff;
      kind_in    = kind_ff;
      pend_v_in  = pend_v_ff;
      pend_id_in = pend_id_ff;
      cnt_in     = cnt_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = '0;
      wr_addr    = e_addr;
      wr_armed   = 1'b0;
      wr_expiry  = time_ff;
      wr_next    = c_ff;
      wr_prev    = p_ff;
      push       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en.armed = 1'b1;
            wr_addr     = clr_ff;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_TIMERS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               id_in     = req_conn_id;
               time_in   = TIME_BITS'(req_expire_time);
               now_in    = TIME_BITS'(req_now_time);
               kind_in   = KIND_DONE;
               pend_v_in = 1'b0;
               cnt_in    = '0;
               if (req_op == OP_TICK) begin
                  if (first_ff == NIL) begin
                     state_in = ST_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = first_ff[AW-1:0];
                     c_in     = first_ff;
                     state_in = ST_TICK_CHK;
                  end
               end else if (32'(req_conn_id) < 32'(MAX_TIMERS)) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(req_conn_id);
                  state_in = ST_CHECK;
               end else begin
                  kind_in  = KIND_NOT_ARMED;
                  state_in = ST_RESP;
               end
            end
         end
         ST_CHECK: begin
            if (op_ff == OP_ADD) begin
               if (rd_armed) begin
                  kind_in  = KIND_ARMED;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_WALK;
               end
            end else if (!rd_armed) begin
               kind_in  = KIND_NOT_ARMED;
               state_in = ST_RESP;
            end else begin
               p_in     = rd_prev;
               c_in     = rd_next;
               state_in = ST_UNL_P;
            end
         end
         ST_UNL_P: begin
            if (p_ff != NIL) begin
               wr_en.next = 1'b1;
               wr_addr    = p_ff[AW-1:0];
               wr_next    = c_ff;
            end else begin
               first_in = c_ff;
            end
            state_in = ST_UNL_N;
         end
         ST_UNL_N: begin
            if (c_ff != NIL) begin
               wr_en.prev = 1'b1;
               wr_addr    = c_ff[AW-1:0];
               wr_prev    = p_ff;
            end else begin
               last_in = p_ff;
            end
            state_in = (op_ff == OP_DEL) ? ST_UNL_E : ST_WALK;
         end
         ST_UNL_E: begin
            wr_en.armed = 1'b1;
            state_in    = ST_RESP;
         end
         ST_WALK: begin
            p_in = NIL;
            c_in = first_ff;
            if (first_ff == NIL) begin
               state_in = ST_INS_E;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = first_ff[AW-1:0];
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (time_ff < rd_expiry) begin
               state_in = ST_INS_E;
            end else begin
               p_in = c_ff;
               c_in = rd_next;
               if (rd_next == NIL) begin
                  state_in = ST_INS_E;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rd_next[AW-1:0];
               end
            end
         end
         ST_INS_E: begin
            wr_en    = '{armed: 1'b1, expiry: 1'b1, next: 1'b1, prev: 1'b1};
            wr_armed = 1'b1;
            state_in = ST_INS_P;
         end
         ST_INS_P: begin
            if (p_ff != NIL) begin
               wr_en.next = 1'b1;
               wr_addr    = p_ff[AW-1:0];
               wr_next    = e_link;
            end else begin
               first_in = e_link;
            end
            state_in = ST_INS_C;
         end
         ST_INS_C: begin
            if (c_ff != NIL) begin
               wr_en.prev = 1'b1;
               wr_addr    = c_ff[AW-1:0];
               wr_prev    = e_link;
            end else begin
               last_in = e_link;
            end
            state_in = ST_RESP;
         end
         ST_TICK_CHK: begin
            if (now_ff < rd_expiry) begin
               state_in = ST_RESP;
            end else begin
               first_in = rd_next;
               p_in     = rd_next;
               state_in = ST_TICK_N;
            end
         end
         ST_TICK_N: begin
            if (p_ff != NIL) begin
               wr_en.prev = 1'b1;
               wr_addr    = p_ff[AW-1:0];
               wr_prev    = NIL;
            end else begin
               last_in = NIL;
            end
            state_in = ST_TICK_H;
         end
         ST_TICK_H: begin
            wr_en.armed = 1'b1;
            wr_addr     = c_ff[AW-1:0];
            if (!pend_v_ff || can_push) begin
               if (pend_v_ff) begin
                  push = '{valid: 1'b1, kind: KIND_EXPIRED,
                           id: ID_W'(pend_id_ff), last: 1'b0};
               end
               pend_v_in  = 1'b1;
               pend_id_in = c_ff;
               cnt_in     = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(RES_CAP - 1) || first_ff == NIL) begin
                  state_in = ST_RESP;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = first_ff[AW-1:0];
                  c_in     = first_ff;
                  state_in = ST_TICK_CHK;
               end
            end
         end
         ST_RESP: begin
            if (can_push) begin
               if (pend_v_ff) begin
                  push = '{valid: 1'b1, kind: KIND_EXPIRED,
                           id: ID_W'(pend_id_ff), last: 1'b1};
               end else begin
                  push = '{valid: 1'b1, kind: kind_ff, id: id_ff, last: 1'b1};
               end
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sorted_timeout_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sorted timer list for up to MAX_TIMERS connections, ordered by expiry.
// req_bus takes one operation (add, delete, adjust, tick) per transfer;
// rsp_bus returns one result per add/delete/adjust and, for a tick, one
// result per expired connection (earliest expiry first) or a single done result.
// The final result of each request has last set.
// Requests are handled one at a time; ready is high only while idle.
// Steps read or write the entry table, which has one write port and
// one read port with a registered output. Add and adjust walk up to
// MAX_TIMERS entries to find the insert point; a tick expires at most
// 64 entries. After reset the armed flags of all MAX_TIMERS entries are
// cleared one by one, during which ready stays low.
// A result waits in an output register; while the receiver stalls, work
// continues until the next result must be handed over.
module sorted_timeout_queue import stq_pkg::*; #(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   stq_req_if.sink   req_bus,
   stq_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(MAX_TIMERS);
   localparam int LW = $clog2(MAX_TIMERS + 1);

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 rd_armed;
   logic [TIME_BITS-1:0] rd_expiry;
   logic [LW-1:0]        rd_next;
   logic [LW-1:0]        rd_prev;
   stq_wr_en_type        wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 wr_armed;
   logic [TIME_BITS-1:0] wr_expiry;
   logic [LW-1:0]        wr_next;
   logic [LW-1:0]        wr_prev;
   stq_push_type         push;
   logic                 can_push;

   logic            out_v_ff, out_v_in;
   kind_type        out_kind_ff, out_kind_in;
   logic [ID_W-1:0] out_id_ff, out_id_in;
   logic            out_last_ff, out_last_in;

   stq_table #(.MAX_TIMERS(MAX_TIMERS), .TIME_BITS(TIME_BITS)) u_table (
      .clock,
      .rd_en,
      .rd_addr,
      .rd_armed,
      .rd_expiry,
      .rd_next,
      .rd_prev,
      .wr_en,
      .wr_addr,
      .wr_armed,
      .wr_expiry,
      .wr_next,
      .wr_prev
   );

   stq_ctrl #(.MAX_TIMERS(MAX_TIMERS), .TIME_BITS(TIME_BITS)) u_ctrl (
      .clock,
      .reset,
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_op          (req_bus.op),
      .req_conn_id     (req_bus.conn_id),
      .req_expire_time (req_bus.expire_time),
      .req_now_time    (req_bus.now_time),
      .can_push,
      .push,
      .rd_en,
      .rd_addr,
      .rd_armed,
      .rd_expiry,
      .rd_next,
      .rd_prev,
      .wr_en,
      .wr_addr,
      .wr_armed,
      .wr_expiry,
      .wr_next,
      .wr_prev
   );

   assign can_push = !out_v_ff || rsp_bus.ready;

   always_comb begin
      out_v_in    = out_v_ff && !rsp_bus.ready;
      out_kind_in = out_kind_ff;
      out_id_in   = out_id_ff;
      out_last_in = out_last_ff;
      if (push.valid) begin
         out_v_in    = 1'b1;
         out_kind_in = push.kind;
         out_id_in   = push.id;
         out_last_in = push.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.kind       = out_kind_ff;
   assign rsp_bus.expired_id = out_id_ff;
   assign rsp_bus.last       = out_last_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> can_push)
      else $error("result pushed while output register is held");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while previous one in progress");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_bus.ready)
      else $error("request taken during table clear");

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (wr_en == '0))
      else $error("table written while idle");

endmodule

`default_nettype wire
